// ===== sv/usvt_pkg.sv =====
// shared types and opcode constants for the unique value set table
package usvt_pkg;

   // request opcodes
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_FIND   = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   // widths of the stored values, the remove position, the match position and the entry count fields
   localparam int VALUE_W = 32;
   localparam int RPOS_W  = 6;
   localparam int MPOS_W  = 6;
   localparam int COUNT_W = 7;

   // control sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic              compare;
      logic              append;
      logic              remove;
      logic [RPOS_W-1:0] rm_pos;
   } cell_cmd_type;

endpackage

// ===== sv/usvt_cell.sv =====
// one table cell: holds an entry, compares it with the key, takes its neighbor on remove
module usvt_cell #(
   parameter int INDEX   = 0,
   parameter int CNT_W   = 7
) (
   input  logic                           clock,
   input  usvt_pkg::cell_cmd_type         cmd,
   input  logic [usvt_pkg::VALUE_W-1:0]   key,
   input  logic [CNT_W-1:0]               count,
   input  logic [usvt_pkg::VALUE_W-1:0]   next_entry,
   output logic [usvt_pkg::VALUE_W-1:0]   entry,
   output logic                           match
);

   localparam int W = CNT_W + usvt_pkg::RPOS_W;

   logic [usvt_pkg::VALUE_W-1:0] entry_ff;
   logic [usvt_pkg::VALUE_W-1:0] entry_in;
   logic                         match_ff;
   logic                         match_in;
   logic                         occupied;
   logic                         at_tail;
   logic                         in_shift;

   // position of this cell against the count and the remove point
   assign occupied = W'(INDEX) < W'(count);
   assign at_tail  = W'(INDEX) == W'(count);
   assign in_shift = (W'(INDEX) >= W'(cmd.rm_pos)) && (W'(INDEX + 1) < W'(count));

   // entry update: append at the tail, or pull the neighbor down on remove
   always_comb begin
      entry_in = entry_ff;
      if (cmd.append && at_tail) begin
         entry_in = key;
      end else if (cmd.remove && in_shift) begin
         entry_in = next_entry;
      end
   end

   // match flag, sampled when the request is taken
   assign match_in = occupied && (entry_ff == key);

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (cmd.compare) begin
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// ===== sv/usvt_first.sv =====
// first-match priority encoder over the match flags of the cells
module usvt_first #(
   parameter int DEPTH = 64
) (
   input  logic [DEPTH-1:0]         match,
   output logic [$clog2(DEPTH)-1:0] first_pos,
   output logic                     any_match
);

   localparam int IW = $clog2(DEPTH);

   // lowest index wins
   always_comb begin
      first_pos = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            first_pos = IW'(i);
         end
      end
   end

   assign any_match = |match;

endmodule

// ===== sv/unique_value_set_table.sv =====
// top level of the unique value set table: sequencer, count and result register
//
//  channel | ports              | direction | accepted when
//  --------+--------------------+-----------+------------------------
//  request | req_valid/req_ready| in        | req_valid && req_ready
//  result  | rsp_valid/rsp_ready| out       | rsp_valid && rsp_ready
//
// on the transfer cycle all cells compare their entry with the value; in the
// execute state the first match is encoded and the cell chain appends or
// shifts in one step while the result is registered.
// a stalled result register holds the table in the execute state until it drains.
// reset clears the state, the count and the result valid flag; entries are never cleared and need no sweep.
module unique_value_set_table #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_opcode,
   input  logic signed [usvt_pkg::VALUE_W-1:0]  req_value,
   input  logic [usvt_pkg::RPOS_W-1:0]          req_remove_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_inserted,
   output logic                                 rsp_found,
   output logic [usvt_pkg::MPOS_W-1:0]          rsp_match_position,
   output logic [usvt_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic                                 rsp_full_refused
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int RW = CW + usvt_pkg::RPOS_W;
   localparam int PW = IW + usvt_pkg::MPOS_W;
   localparam int OW = CW + usvt_pkg::COUNT_W;

   usvt_pkg::state_type state_ff;
   usvt_pkg::state_type state_in;

   // request hold registers
   logic [1:0]                     op_ff;
   logic [usvt_pkg::VALUE_W-1:0]   value_ff;
   logic [usvt_pkg::RPOS_W-1:0]    rpos_ff;

   logic [CW-1:0]                  count_ff;
   logic [CW-1:0]                  count_in;

   // result register
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic                           inserted_ff;
   logic                           inserted_in;
   logic                           found_ff;
   logic                           found_in;
   logic [usvt_pkg::MPOS_W-1:0]    mpos_ff;
   logic [usvt_pkg::MPOS_W-1:0]    mpos_in;
   logic [usvt_pkg::COUNT_W-1:0]   ecount_ff;
   logic [usvt_pkg::COUNT_W-1:0]   ecount_in;
   logic                           refused_ff;
   logic                           refused_in;

   logic                           req_xfer;
   logic                           exec_fire;
   logic                           do_append;
   logic                           do_remove;
   logic [usvt_pkg::VALUE_W-1:0]   key;
   usvt_pkg::cell_cmd_type         cmd;

   logic [TABLE_DEPTH-1:0]         match_vec;
   logic [usvt_pkg::VALUE_W-1:0]   cell_entry [TABLE_DEPTH];
   logic [IW-1:0]                  first_pos;
   logic                           any_match;
   logic [PW-1:0]                  pos_ext;
   logic [OW-1:0]                  cnt_ext;

   assign req_ready = !reset && (state_ff == usvt_pkg::ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign exec_fire = (state_ff == usvt_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   // key on the cell bus: live request value on transfer, held value afterwards
   assign key = req_xfer ? req_value : value_ff;

   assign cmd.compare = req_xfer;
   assign cmd.append  = exec_fire && do_append;
   assign cmd.remove  = exec_fire && do_remove;
   assign cmd.rm_pos  = rpos_ff;

   // chain of cells
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [usvt_pkg::VALUE_W-1:0] nbr;
      if (i == TABLE_DEPTH - 1) begin : g_last
         assign nbr = '0;
      end else begin : g_mid
         assign nbr = cell_entry[i+1];
      end
      usvt_cell #(
         .INDEX (i),
         .CNT_W (CW)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .key        (key),
         .count      (count_ff),
         .next_entry (nbr),
         .entry      (cell_entry[i]),
         .match      (match_vec[i])
      );
   end

   usvt_first #(
      .DEPTH (TABLE_DEPTH)
   ) u_first (
      .match     (match_vec),
      .first_pos (first_pos),
      .any_match (any_match)
   );

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= usvt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state, operation decode and result fields
   always_comb begin
      state_in    = state_ff;
      do_append   = 1'b0;
      do_remove   = 1'b0;
      inserted_in = 1'b0;
      found_in    = 1'b0;
      refused_in  = 1'b0;
      pos_ext     = '0;
      count_in    = count_ff;

      unique case (state_ff)
         usvt_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = usvt_pkg::ST_EXEC;
            end
         end
         usvt_pkg::ST_EXEC: begin
            if (exec_fire) begin
               state_in = usvt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = usvt_pkg::ST_IDLE;
         end
      endcase

      case (op_ff)
         usvt_pkg::OP_ADD: begin
            if (any_match) begin
               found_in = 1'b1;
               pos_ext  = PW'(first_pos);
            end else if (count_ff < CW'(TABLE_DEPTH)) begin
               do_append   = 1'b1;
               inserted_in = 1'b1;
               count_in    = count_ff + CW'(1);
            end else begin
               refused_in = 1'b1;
            end
         end
         usvt_pkg::OP_FIND: begin
            if (any_match) begin
               found_in = 1'b1;
               pos_ext  = PW'(first_pos);
            end
         end
         usvt_pkg::OP_REMOVE: begin
            if (RW'(rpos_ff) < RW'(count_ff)) begin
               do_remove = 1'b1;
               count_in  = count_ff - CW'(1);
            end
         end
         default: begin
         end
      endcase

      cnt_ext   = OW'(count_in);
      mpos_in   = pos_ext[usvt_pkg::MPOS_W-1:0];
      ecount_in = cnt_ext[usvt_pkg::COUNT_W-1:0];
   end

   assign rsp_valid_in = exec_fire || (rsp_valid_ff && !rsp_ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (exec_fire) begin
            count_ff <= count_in;
         end
      end
   end

   // request capture and result payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff    <= req_opcode;
         value_ff <= req_value;
         rpos_ff  <= req_remove_position;
      end
      if (exec_fire) begin
         inserted_ff <= inserted_in;
         found_ff    <= found_in;
         mpos_ff     <= mpos_in;
         ecount_ff   <= ecount_in;
         refused_ff  <= refused_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_inserted       = inserted_ff;
   assign rsp_found          = found_ff;
   assign rsp_match_position = mpos_ff;
   assign rsp_entry_count    = ecount_ff;
   assign rsp_full_refused   = refused_ff;

   // count stays within the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // an append grows the count by one
   a_append_count: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && do_append) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("append did not grow the count");

   // a first match always lies among the stored entries
   a_match_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == usvt_pkg::ST_EXEC) && any_match) |-> (RW'(first_pos) < RW'(count_ff)))
      else $error("match reported beyond the count");

   // the table never changes while a result is stalled
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == usvt_pkg::ST_EXEC) && !exec_fire) |=> $stable(count_ff))
      else $error("count moved during a stall");

   // a result never reports a store together with a refusal or a find
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      exec_fire |-> !(inserted_in && (refused_in || found_in)))
      else $error("conflicting add flags");

endmodule
